// ===== hdl/point_light_attenuation_core_defines.svh =====
// Assertion macros shared by the point light attenuation RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef POINT_LIGHT_ATTENUATION_CORE_DEFINES_SVH
`define POINT_LIGHT_ATTENUATION_CORE_DEFINES_SVH

// Check a property at every clock edge outside reset
`define PLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every clock edge, reset included
`define PLA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pla_pkg.sv =====
// Types and constants of the point light attenuation core.
// No dependencies; used by every module of the block.
package pla_pkg;

  localparam int COORD_W     = 24;
  localparam int COEF_W      = 24;
  localparam int SQ_W        = 50;
  localparam int DIST_W      = 25;
  localparam int DEN_W       = 51;
  localparam int QUOT_W      = 8;
  localparam int LANES       = 3;
  localparam int SQRT_STAGES = 25;

  localparam logic [COEF_W-1:0] COEF_ONE = 24'h010000;

  typedef enum logic [2:0] {
    CFG_LIGHT_X        = 3'd0,
    CFG_LIGHT_Y        = 3'd1,
    CFG_LIGHT_Z        = 3'd2,
    CFG_LIGHT_RGB      = 3'd3,
    CFG_COEF_CONSTANT  = 3'd4,
    CFG_COEF_LINEAR    = 3'd5,
    CFG_COEF_QUADRATIC = 3'd6,
    CFG_AMBIENT_MODE   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       clipped;
  } out_rsp_t;

  // Special-case flags decided from the denominator
  typedef struct packed {
    logic             zero;
    logic [LANES-1:0] sat;
  } div_flags_t;

endpackage

// ===== hdl/pla_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on pla_pkg.
module pla_sqrt
  import pla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_sq,
  output logic              out_valid,
  output logic [DIST_W-1:0] out_root
);

  logic [SQ_W-1:0] rem_r   [SQRT_STAGES];
  logic [SQ_W-1:0] res_r   [SQRT_STAGES];
  logic [SQ_W-1:0] rem_nxt [SQRT_STAGES];
  logic [SQ_W-1:0] res_nxt [SQRT_STAGES];
  logic            vld_r   [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << (SQ_W - 2 - 2 * g);
    logic [SQ_W-1:0] rem_in;
    logic [SQ_W-1:0] res_in;
    logic            vld_in;
    logic [SQ_W:0]   trial;

    if (g == 0) begin : g_first
      assign rem_in = in_sq;
      assign res_in = '0;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign res_in = res_r[g-1];
      assign vld_in = vld_r[g-1];
    end

    // Try one root bit and keep it when the remainder allows
    always_comb begin
      trial = {1'b0, res_in} + {1'b0, BIT_VAL};
      if ({1'b0, rem_in} >= trial) begin
        rem_nxt[g] = rem_in - trial[SQ_W-1:0];
        res_nxt[g] = (res_in >> 1) + BIT_VAL;
      end else begin
        rem_nxt[g] = rem_in;
        res_nxt[g] = res_in >> 1;
      end
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
      if (en) begin
        rem_r[g] <= rem_nxt[g];
        res_r[g] <= res_nxt[g];
      end
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign out_root  = res_r[SQRT_STAGES-1][DIST_W-1:0];

endmodule

// ===== hdl/pla_div.sv =====
// Pipelined 8-bit quotient divider for the three color lanes, plus the
// zero and saturation flags. Depends on pla_pkg.
module pla_div
  import pla_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [DEN_W-1:0]        in_den,
  input  logic [LANES*8-1:0]      in_rgb,
  output logic                    out_valid,
  output logic [LANES*QUOT_W-1:0] out_quot,
  output div_flags_t              out_flags
);

  localparam int NUM_W = 8 + 16;
  localparam int CMP_W = DEN_W + QUOT_W;

  logic [NUM_W-1:0]  rem_r   [QUOT_W][LANES];
  logic [QUOT_W-1:0] quo_r   [QUOT_W][LANES];
  logic [NUM_W-1:0]  rem_nxt [QUOT_W][LANES];
  logic [QUOT_W-1:0] quo_nxt [QUOT_W][LANES];
  logic [DEN_W-1:0]  den_r   [QUOT_W];
  div_flags_t        flg_r   [QUOT_W];
  logic              vld_r   [QUOT_W];
  div_flags_t        flg_first;

  // Decide zero and saturation from the incoming denominator
  always_comb begin
    flg_first.zero = (in_den == '0);
    for (int l = 0; l < LANES; l++) begin
      flg_first.sat[l] = !flg_first.zero &&
        (in_den <= DEN_W'({in_rgb[8*(LANES-1-l) +: 8], 8'h00}));
    end
  end

  for (genvar g = 0; g < QUOT_W; g++) begin : g_stage
    localparam int K = QUOT_W - 1 - g;
    logic [DEN_W-1:0]  den_in;
    div_flags_t        flg_in;
    logic              vld_in;
    logic [CMP_W-1:0]  dsh;
    logic [NUM_W-1:0]  rin [LANES];
    logic [QUOT_W-1:0] qin [LANES];

    if (g == 0) begin : g_first
      assign den_in = in_den;
      assign flg_in = flg_first;
      assign vld_in = in_valid;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rin[l] = {in_rgb[8*(LANES-1-l) +: 8], 16'h0000};
        assign qin[l] = '0;
      end
    end else begin : g_next
      assign den_in = den_r[g-1];
      assign flg_in = flg_r[g-1];
      assign vld_in = vld_r[g-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rin[l] = rem_r[g-1][l];
        assign qin[l] = quo_r[g-1][l];
      end
    end

    assign dsh = {{QUOT_W{1'b0}}, den_in} << K;

    // Compare and subtract one quotient bit per lane
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (CMP_W'(rin[l]) >= dsh) begin
          rem_nxt[g][l] = rin[l] - dsh[NUM_W-1:0];
          quo_nxt[g][l] = qin[l] | (QUOT_W'(1) << K);
        end else begin
          rem_nxt[g][l] = rin[l];
          quo_nxt[g][l] = qin[l];
        end
      end
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
      if (en) begin
        den_r[g] <= den_in;
        flg_r[g] <= flg_in;
        for (int l = 0; l < LANES; l++) begin
          rem_r[g][l] <= rem_nxt[g][l];
          quo_r[g][l] <= quo_nxt[g][l];
        end
      end
    end
  end

  assign out_valid = vld_r[QUOT_W-1];
  assign out_flags = flg_r[QUOT_W-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_quot[QUOT_W*(LANES-1-l) +: QUOT_W] = quo_r[QUOT_W-1][l];
  end

endmodule

// ===== hdl/point_light_attenuation_core.sv =====
// Top level of the point light attenuation core: config registers,
// distance and denominator stages. Uses pla_pkg, pla_sqrt, pla_div.
//
//   port group | dir | handshake      | payload
//   in_        | in  | valid / ready  | in_req_t (point x, y, z)
//   out_       | out | valid / ready  | out_rsp_t (red, green, blue, clipped)
//   cfg_       | in  | write enable   | 3-bit index, 24-bit data
//
// One point enters per clock while the output is not stalled. The pipeline is
// 3 distance stages, 25 square root stages (one root bit each), 4 denominator
// stages, 8 divider stages (one quotient bit each) and the output register.
// Reset is synchronous and empties the pipeline; config takes reset values.
// A stalled output freezes every stage; nothing is dropped or repeated.
module point_light_attenuation_core
  import pla_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_req_t       in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output out_rsp_t      out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_wdata
);

`include "point_light_attenuation_core_defines.svh"

  logic signed [COORD_W-1:0] light_x_r, light_y_r, light_z_r;
  logic [23:0]               light_rgb_r;
  logic [COEF_W-1:0]         coef_c_r, coef_l_r, coef_q_r;
  logic                      ambient_mode_r;

  logic              en;
  logic              v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic [COORD_W-1:0] ad_r  [3];
  logic [COORD_W-1:0] ad_nxt[3];
  logic [47:0]       sq_r  [3];
  logic [SQ_W-1:0]   s_r;
  logic              sqrt_valid;
  logic [DIST_W-1:0] root;
  logic [DIST_W-1:0] d_r;
  logic [SQ_W-1:0]   dd_r;
  logic [48:0]       ld_r, ld6_r, pql_r, pqh_r;
  logic [DEN_W-1:0]  den_r;
  logic              div_valid;
  logic [23:0]       div_quot;
  div_flags_t        div_flags;
  logic              zero_r;
  out_rsp_t          out_r, out_nxt;
  logic              out_valid_r;

  // Hold configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r      <= '0;
      light_y_r      <= '0;
      light_z_r      <= '0;
      light_rgb_r    <= '0;
      coef_c_r       <= COEF_ONE;
      coef_l_r       <= '0;
      coef_q_r       <= '0;
      ambient_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LIGHT_X:        light_x_r      <= cfg_wdata;
        CFG_LIGHT_Y:        light_y_r      <= cfg_wdata;
        CFG_LIGHT_Z:        light_z_r      <= cfg_wdata;
        CFG_LIGHT_RGB:      light_rgb_r    <= cfg_wdata;
        CFG_COEF_CONSTANT:  coef_c_r       <= cfg_wdata;
        CFG_COEF_LINEAR:    coef_l_r       <= cfg_wdata;
        CFG_COEF_QUADRATIC: coef_q_r       <= cfg_wdata;
        CFG_AMBIENT_MODE:   ambient_mode_r <= cfg_wdata[0];
        default:            ambient_mode_r <= ambient_mode_r;
      endcase
    end
  end

  // Advance the whole pipeline unless the output request is stuck
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Take absolute coordinate differences
  always_comb begin
    logic signed [COORD_W:0] df [3];
    df[0] = $signed({light_x_r[COORD_W-1], light_x_r}) -
            $signed({in_data.point_x[COORD_W-1], in_data.point_x});
    df[1] = $signed({light_y_r[COORD_W-1], light_y_r}) -
            $signed({in_data.point_y[COORD_W-1], in_data.point_y});
    df[2] = $signed({light_z_r[COORD_W-1], light_z_r}) -
            $signed({in_data.point_z[COORD_W-1], in_data.point_z});
    for (int i = 0; i < 3; i++) begin
      ad_nxt[i] = df[i][COORD_W] ? COORD_W'(-df[i]) : COORD_W'(df[i]);
    end
  end

  // Distance and denominator stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= sqrt_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ad_r[i] <= ad_nxt[i];
        sq_r[i] <= ad_r[i] * ad_r[i];
      end
      s_r   <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
      d_r   <= (root == '0) ? DIST_W'(1) : root;
      dd_r  <= d_r * d_r;
      ld_r  <= coef_l_r * d_r;
      pql_r <= coef_q_r * dd_r[24:0];
      pqh_r <= coef_q_r * dd_r[49:25];
      ld6_r <= ld_r;
      den_r <= DEN_W'({pqh_r, 1'b0}) + DEN_W'(pql_r[48:24]) +
               DEN_W'(ld6_r[48:8]) + DEN_W'(coef_c_r);
    end
  end

  pla_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_sq     (s_r),
    .out_valid (sqrt_valid),
    .out_root  (root)
  );

  pla_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v7_r),
    .in_den    (den_r),
    .in_rgb    (light_rgb_r),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_flags (div_flags)
  );

  // Apply zero, saturation and ambient overrides
  always_comb begin
    logic [7:0] ch [3];
    logic [7:0] res [3];
    for (int l = 0; l < 3; l++) begin
      ch[l] = light_rgb_r[8*(2-l) +: 8];
      if (div_flags.zero) begin
        res[l] = (ch[l] != 8'h00) ? 8'hFF : 8'h00;
      end else if (div_flags.sat[l]) begin
        res[l] = 8'hFF;
      end else begin
        res[l] = div_quot[8*(2-l) +: 8];
      end
    end
    if (ambient_mode_r) begin
      out_nxt = '{out_red: ch[0], out_green: ch[1], out_blue: ch[2], clipped: 1'b0};
    end else begin
      out_nxt = '{out_red: res[0], out_green: res[1], out_blue: res[2],
                  clipped: div_flags.zero | (|div_flags.sat)};
    end
  end

  // Hold the result until the request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
    if (en) begin
      out_r  <= out_nxt;
      zero_r <= div_flags.zero && !ambient_mode_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PLA_ASSERT(a_ambient_no_clip, out_valid && ambient_mode_r |-> !out_data.clipped, "clip in ambient mode")
  `PLA_ASSERT(a_clip_cause, out_valid && out_data.clipped |-> zero_r || out_data.out_red == 8'hFF || out_data.out_green == 8'hFF || out_data.out_blue == 8'hFF, "clip without saturated channel")
  `PLA_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")
  `PLA_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

endmodule
